// ----- design/cmr_pkg.sv -----
`timescale 1ns / 1ps
package cmr_pkg;
  localparam int unsigned NumSources = 128;
  localparam int unsigned MaxFrames = 64;
  localparam int unsigned SrcW = $clog2(NumSources);
  localparam int unsigned SeqW = $clog2(MaxFrames);
  localparam int unsigned MemAw = SrcW + SeqW;

  typedef enum logic [1:0] {
    KindSingle = 2'd0,
    KindHead = 2'd1,
    KindMiddle = 2'd2,
    KindTail = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    StStored = 3'd0,
    StWord = 3'd1,
    StErrFrame = 3'd2,
    StReject = 3'd3,
    StSeqFail = 3'd4,
    StTagFail = 3'd5
  } status_e;

  typedef struct packed {
    logic [6:0] source_address;
    logic [1:0] frame_kind;
    logic [5:0] sequence_number;
    logic [2:0] message_tag;
    logic error_flag;
    logic [63:0] payload;
  } req_t;

  typedef struct packed {
    logic [63:0] word_out;
    logic last_word;
    logic [2:0] status;
    logic [31:0] error_frame_total;
    logic [31:0] tag_error_total;
  } rsp_t;
endpackage

// ----- design/cmr_front.sv -----
`timescale 1ns / 1ps
module cmr_front (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  cmr_pkg::req_t req_i,
  input  logic q_full_i,
  output logic q_push_o,
  output cmr_pkg::req_t q_data_o
);
  import cmr_pkg::*;
  logic hold_q;
  logic hold_d;
  req_t data_q;

  assign busy_o = hold_q;
  assign q_push_o = hold_q && !q_full_i;
  assign q_data_o = data_q;

  always_comb begin
    hold_d = hold_q;
    if (q_push_o) begin
      hold_d = 1'b0;
    end
    if (start_i && !hold_q) begin
      hold_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !hold_q) begin
      data_q <= req_i;
    end
  end
endmodule

// ----- design/cmr_queue.sv -----
`timescale 1ns / 1ps
module cmr_queue (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmr_pkg::req_t push_data_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmr_pkg::req_t pop_data_o
);
  import cmr_pkg::*;
  req_t mem_q [2];
  logic wr_q;
  logic rd_q;
  logic [1:0] cnt_q;

  assign full_o = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end
endmodule

// ----- design/cmr_back.sv -----
`timescale 1ns / 1ps
module cmr_back (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic [6:0] own_address_i,
  input  logic valid_i,
  output logic pop_o,
  input  cmr_pkg::req_t req_i,
  output logic done_o,
  output cmr_pkg::rsp_t rsp_o
);
  import cmr_pkg::*;

  typedef enum logic [4:0] {
    SClear = 5'b00001,
    SIdle = 5'b00010,
    SRead = 5'b00100,
    SExec = 5'b01000,
    SOut = 5'b10000
  } state_e;

  typedef struct packed {
    logic head_seen;
    logic [5:0] cnt;
    logic [2:0] htag;
    logic [5:0] mism;
    logic [MaxFrames-1:0] written;
  } entry_t;

  state_e state_q;
  req_t cur_q;
  entry_t ent_mem [NumSources];
  entry_t ent_q;
  entry_t ent_wdata;
  logic ent_we;
  logic [SrcW-1:0] ent_waddr;
  logic [SrcW-1:0] clr_q;
  logic [63:0] store_q [NumSources*MaxFrames];
  logic store_we;
  logic [MaxFrames-1:0] mask_q;
  logic [31:0] err_tot_q;
  logic [31:0] tag_tot_q;
  logic [SeqW-1:0] idx_q;
  logic [63:0] rd_data_q;
  logic [SrcW-1:0] src;
  logic [SeqW-1:0] seq_idx;
  logic seq_ok;
  logic rejected;
  logic seq_fail;
  logic [MaxFrames-1:0] seq_bit;
  logic [MaxFrames-1:0] written_new;
  logic [5:0] cnt_new;
  logic [5:0] mism_new;
  logic [32:0] tag_sum;
  logic emit_last;

  assign src = cur_q.source_address[SrcW-1:0];
  assign seq_idx = cur_q.sequence_number[SeqW-1:0];
  assign seq_ok = {26'd0, cur_q.sequence_number} < 32'(MaxFrames);
  assign rejected = ({1'b0, cur_q.source_address} >= 8'(NumSources)) ||
                    (cur_q.source_address == own_address_i);
  assign seq_bit = seq_ok ? (MaxFrames'(1) << seq_idx) : '0;
  assign written_new = ent_q.written | seq_bit;
  assign cnt_new = ent_q.cnt + 6'd1;
  assign mism_new = (cur_q.message_tag != ent_q.htag && ent_q.mism != 6'd63) ?
                    ent_q.mism + 6'd1 : ent_q.mism;
  assign seq_fail = cnt_new != cur_q.sequence_number || !ent_q.head_seen || !seq_ok;
  assign tag_sum = {1'b0, tag_tot_q} + {27'd0, mism_new};
  assign pop_o = (state_q == SIdle) && valid_i;
  assign emit_last = idx_q == seq_idx;
  assign store_we = state_q == SExec && cur_q.frame_kind != KindSingle &&
                    !cur_q.error_flag && !rejected && seq_ok;

  always_comb begin
    ent_we = 1'b0;
    ent_waddr = src;
    ent_wdata = ent_q;
    if (state_q == SClear) begin
      ent_we = 1'b1;
      ent_waddr = clr_q;
      ent_wdata = '0;
    end else if (state_q == SExec && !cur_q.error_flag && !rejected) begin
      unique case (cur_q.frame_kind)
        KindSingle: begin
          ent_we = 1'b0;
        end
        KindHead: begin
          ent_we = 1'b1;
          ent_wdata = '0;
          ent_wdata.head_seen = 1'b1;
          ent_wdata.htag = cur_q.message_tag;
          ent_wdata.written = seq_bit;
        end
        KindMiddle: begin
          ent_we = 1'b1;
          ent_wdata.cnt = cnt_new;
          ent_wdata.mism = mism_new;
          ent_wdata.written = written_new;
        end
        KindTail: begin
          ent_we = 1'b1;
          ent_wdata.cnt = cnt_new;
          ent_wdata.written = written_new;
          if (!seq_fail) begin
            ent_wdata = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (pop_o) begin
      cur_q <= req_i;
      ent_q <= ent_mem[req_i.source_address[SrcW-1:0]];
    end
    if (store_we) begin
      store_q[{src, seq_idx}] <= cur_q.payload;
    end
    if (state_q == SExec) begin
      mask_q <= written_new;
    end
    rd_data_q <= store_q[{src, idx_q}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      clr_q <= '0;
      err_tot_q <= '0;
      tag_tot_q <= '0;
      idx_q <= '0;
      done_o <= 1'b0;
      rsp_o <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        SClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == SrcW'(NumSources - 1)) begin
            state_q <= SIdle;
          end
        end
        SIdle: begin
          if (pop_o) begin
            state_q <= SExec;
          end
        end
        SExec: begin
          rsp_o.word_out <= '0;
          rsp_o.last_word <= 1'b1;
          rsp_o.error_frame_total <= err_tot_q;
          rsp_o.tag_error_total <= tag_tot_q;
          done_o <= 1'b1;
          state_q <= SIdle;
          idx_q <= '0;
          if (cur_q.error_flag) begin
            rsp_o.status <= StErrFrame;
            if (err_tot_q != '1) begin
              err_tot_q <= err_tot_q + 32'd1;
              rsp_o.error_frame_total <= err_tot_q + 32'd1;
            end
          end else if (rejected) begin
            rsp_o.status <= StReject;
          end else begin
            unique case (cur_q.frame_kind)
              KindSingle: begin
                rsp_o.status <= StWord;
                rsp_o.word_out <= cur_q.payload;
              end
              KindHead: begin
                rsp_o.status <= StStored;
              end
              KindMiddle: begin
                rsp_o.status <= StStored;
              end
              KindTail: begin
                if (seq_fail) begin
                  rsp_o.status <= StSeqFail;
                end else if (mism_new != 6'd0) begin
                  rsp_o.status <= StTagFail;
                  tag_tot_q <= tag_sum[32] ? '1 : tag_sum[31:0];
                  rsp_o.tag_error_total <= tag_sum[32] ? '1 : tag_sum[31:0];
                end else begin
                  done_o <= 1'b0;
                  state_q <= SRead;
                end
              end
            endcase
          end
        end
        SRead: begin
          state_q <= SOut;
        end
        SOut: begin
          done_o <= 1'b1;
          rsp_o.status <= StWord;
          rsp_o.word_out <= mask_q[idx_q] ? rd_data_q : '0;
          rsp_o.last_word <= emit_last;
          rsp_o.error_frame_total <= err_tot_q;
          rsp_o.tag_error_total <= tag_tot_q;
          idx_q <= idx_q + 1'b1;
          if (emit_last) begin
            state_q <= SIdle;
          end else begin
            state_q <= SRead;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end
endmodule

// ----- design/can_multiframe_reassembler.sv -----
`timescale 1ns / 1ps
// An accepted request is held in the front register, pushed into the queue and popped by the back part.
// Requests other than a successful tail are carried out one at a time in its idle and execute states.
// A successful tail with sequence number n gives n+1 words, each read from the store in a read
// state and given out in an output state; it holds the back part until its last word is out.
// Reset clears the counters and the own address at once; the reassembly entries are
// cleared one by one in a clear state, during which requests wait. Results cannot be stalled.
module can_multiframe_reassembler (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmr_pkg::req_t req_i,
  input  logic cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  output logic strobe_o,
  output cmr_pkg::rsp_t rsp_o
);
  import cmr_pkg::*;
  logic [6:0] own_q;
  logic q_full;
  logic q_push;
  req_t q_in;
  logic q_valid;
  logic q_pop;
  req_t q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q <= '0;
    end else if (cfg_we_i) begin
      own_q <= cfg_wdata_i;
    end
  end

  cmr_front u_front (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .req_i,
    .q_full_i(q_full), .q_push_o(q_push), .q_data_o(q_in)
  );

  cmr_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .push_data_i(q_in), .full_o(q_full),
    .valid_o(q_valid), .pop_i(q_pop), .pop_data_o(q_out)
  );

  cmr_back u_back (
    .clk_i, .rst_ni, .own_address_i(own_q), .valid_i(q_valid), .pop_o(q_pop),
    .req_i(q_out), .done_o(strobe_o), .rsp_o
  );
endmodule
